### sv/snmp_response_value_extractor_defines.svh
// assertion macros used by the checker file
`ifndef SNMP_RESPONSE_VALUE_EXTRACTOR_DEFINES_SVH
`define SNMP_RESPONSE_VALUE_EXTRACTOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SRVE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srve check failed");

// next-cycle implication, sampled on clk, off during reset
`define SRVE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srve check failed");

`endif

### sv/srve_pkg.sv
package srve_pkg;

  localparam int MAX_DATAGRAM = 2048;
  // byte position saturates at MAX_DATAGRAM + 1
  localparam int POS_W = $clog2(MAX_DATAGRAM + 2);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_DATAGRAM);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_DATAGRAM + 1);

  localparam int LEN_W = 32;
  localparam int VLEN_W = 12;

  localparam logic [7:0] TAG_SEQUENCE = 8'h30;
  localparam logic [7:0] TAG_OID = 8'h06;
  localparam logic [6:0] MAX_LEN_OCTETS = 7'd4;

  // path positions
  localparam logic [3:0] STEP_MESSAGE = 4'd0;
  localparam logic [3:0] STEP_PDU = 4'd3;
  localparam logic [3:0] STEP_VB_LIST = 4'd7;
  localparam logic [3:0] STEP_VARBIND = 4'd8;
  localparam logic [3:0] STEP_OID = 4'd9;
  localparam logic [3:0] STEP_VALUE_HDR = 4'd10;
  localparam logic [3:0] STEP_VALUE_DATA = 4'd11;
  localparam logic [3:0] STEP_FINISHED = 4'd12;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PH_TAG,
    PH_LEN_FIRST,
    PH_LEN_LONG,
    PH_BODY
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_TRUNC,
    ST_TAG,
    ST_FORM
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic              byte_valid;
    logic [7:0]        value_byte;
    logic              done_res;
    status_t           status;
    logic [7:0]        value_tag;
    logic [VLEN_W-1:0] value_length;
  } out_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // tag demanded at a path position; any tag where check is low
  function automatic logic tag_checked(input logic [3:0] step);
    tag_checked = (step == STEP_MESSAGE) || (step == STEP_VB_LIST) ||
                  (step == STEP_VARBIND) || (step == STEP_OID);
  endfunction

  function automatic logic [7:0] tag_wanted(input logic [3:0] step);
    tag_wanted = (step == STEP_OID) ? TAG_OID : TAG_SEQUENCE;
  endfunction

endpackage

### sv/srve_front.sv
module srve_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             rx_valid,
  input  srve_pkg::in_t    rx_data,
  input  srve_pkg::q_stat_t q_stat,
  output logic             rx_stall,
  output logic             push,
  output srve_pkg::out_t   push_data
);

  logic [3:0]                  step, step_next;
  srve_pkg::phase_t            phase, phase_next;
  logic [2:0]                  left, left_next;
  logic [srve_pkg::LEN_W-1:0]  accum, accum_next;
  logic [7:0]                  tag, tag_next;
  logic [srve_pkg::POS_W-1:0]  pos, pos_next;
  logic [srve_pkg::POS_W-1:0]  skip, skip_next;
  logic [srve_pkg::POS_W-1:0]  req_end, req_end_next;
  srve_pkg::status_t           err, err_next;

  logic accept;

  assign rx_stall = q_stat.full;
  assign accept   = rx_valid && !q_stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= srve_pkg::STEP_MESSAGE;
      phase   <= srve_pkg::PH_TAG;
      left    <= '0;
      accum   <= '0;
      tag     <= '0;
      pos     <= '0;
      skip    <= '0;
      req_end <= '0;
      err     <= srve_pkg::ST_OK;
    end else begin
      step    <= step_next;
      phase   <= phase_next;
      left    <= left_next;
      accum   <= accum_next;
      tag     <= tag_next;
      pos     <= pos_next;
      skip    <= skip_next;
      req_end <= req_end_next;
      err     <= err_next;
    end
  end

  always_comb begin
    logic                        process;
    logic                        fin;
    logic [srve_pkg::LEN_W-1:0]  fin_len;
    logic [srve_pkg::LEN_W-1:0]  acc_new;
    logic [srve_pkg::POS_W:0]    end_sum;
    logic [srve_pkg::POS_W-1:0]  end_val;
    logic [srve_pkg::POS_W-1:0]  clamped;
    logic [srve_pkg::POS_W-1:0]  skip_dec;
    logic                        emit_byte;
    logic [7:0]                  b;

    step_next    = step;
    phase_next   = phase;
    left_next    = left;
    accum_next   = accum;
    tag_next     = tag;
    pos_next     = pos;
    skip_next    = skip;
    req_end_next = req_end;
    err_next     = err;
    process      = 1'b0;
    fin          = 1'b0;
    fin_len      = '0;
    acc_new      = '0;
    end_sum      = '0;
    end_val      = '0;
    clamped      = '0;
    skip_dec     = '0;
    emit_byte    = 1'b0;
    b            = rx_data.in_byte;
    push         = 1'b0;
    push_data    = '0;

    if (accept) begin
      if (pos <= srve_pkg::POS_MAX) begin
        pos_next = pos + 1'b1;
        process  = (pos < srve_pkg::POS_MAX);
      end

      if (process && (step < srve_pkg::STEP_FINISHED)) begin
        unique case (phase)
          srve_pkg::PH_TAG: begin
            tag_next = b;
            if (srve_pkg::tag_checked(step) && (b != srve_pkg::tag_wanted(step)) &&
                (err == srve_pkg::ST_OK)) begin
              err_next = srve_pkg::ST_TAG;
            end
            phase_next = srve_pkg::PH_LEN_FIRST;
          end
          srve_pkg::PH_LEN_FIRST: begin
            if (!b[7]) begin
              fin     = 1'b1;
              fin_len = srve_pkg::LEN_W'(b);
            end else if ((b[6:0] == 7'd0) || (b[6:0] > srve_pkg::MAX_LEN_OCTETS)) begin
              if (err == srve_pkg::ST_OK) begin
                err_next = srve_pkg::ST_FORM;
              end
              step_next  = srve_pkg::STEP_FINISHED;
              phase_next = srve_pkg::PH_TAG;
            end else begin
              left_next  = b[2:0];
              accum_next = '0;
              phase_next = srve_pkg::PH_LEN_LONG;
            end
          end
          srve_pkg::PH_LEN_LONG: begin
            acc_new    = {accum[srve_pkg::LEN_W-9:0], b};
            accum_next = acc_new;
            left_next  = left - 1'b1;
            if (left == 3'd1) begin
              fin     = 1'b1;
              fin_len = acc_new;
            end
          end
          srve_pkg::PH_BODY: begin
            emit_byte = (step == srve_pkg::STEP_VALUE_DATA);
            skip_dec  = (skip != '0) ? skip - 1'b1 : skip;
            skip_next = skip_dec;
            if (skip_dec == '0) begin
              step_next  = (step == srve_pkg::STEP_VALUE_DATA) ? srve_pkg::STEP_FINISHED
                                                               : step + 4'd1;
              phase_next = srve_pkg::PH_TAG;
            end
          end
          default: ;
        endcase

        // end of a header: record declared end, then advance the path or enter its body
        if (fin) begin
          accum_next = fin_len;
          if (fin_len > srve_pkg::LEN_W'(srve_pkg::MAX_DATAGRAM)) begin
            end_val = srve_pkg::POS_LIMIT;
            clamped = srve_pkg::POS_LIMIT;
          end else begin
            clamped = fin_len[srve_pkg::POS_W-1:0];
            end_sum = {1'b0, pos_next} + {1'b0, clamped};
            end_val = (end_sum > (srve_pkg::POS_W+1)'(srve_pkg::MAX_DATAGRAM)) ?
                      srve_pkg::POS_LIMIT : end_sum[srve_pkg::POS_W-1:0];
          end
          if (end_val > req_end) begin
            req_end_next = end_val;
          end
          phase_next = srve_pkg::PH_TAG;
          if (err != srve_pkg::ST_OK) begin
            step_next = srve_pkg::STEP_FINISHED;
          end else begin
            case (step)
              srve_pkg::STEP_MESSAGE, srve_pkg::STEP_PDU,
              srve_pkg::STEP_VB_LIST, srve_pkg::STEP_VARBIND: begin
                step_next = step + 4'd1;
              end
              srve_pkg::STEP_VALUE_HDR: begin
                if (fin_len == '0) begin
                  step_next = srve_pkg::STEP_FINISHED;
                end else begin
                  step_next  = srve_pkg::STEP_VALUE_DATA;
                  skip_next  = clamped;
                  phase_next = srve_pkg::PH_BODY;
                end
              end
              default: begin
                if (fin_len == '0) begin
                  step_next = step + 4'd1;
                end else begin
                  skip_next  = clamped;
                  phase_next = srve_pkg::PH_BODY;
                end
              end
            endcase
          end
        end
      end

      push                 = emit_byte || rx_data.last_byte;
      push_data.byte_valid = emit_byte;
      push_data.value_byte = emit_byte ? b : 8'd0;
      push_data.done_res   = rx_data.last_byte;

      if (rx_data.last_byte) begin
        if ((pos_next > srve_pkg::POS_MAX) || (pos_next < req_end_next) ||
            (step_next != srve_pkg::STEP_FINISHED)) begin
          push_data.status = srve_pkg::ST_TRUNC;
        end else begin
          push_data.status = err_next;
        end
        if (push_data.status == srve_pkg::ST_OK) begin
          push_data.value_tag    = tag_next;
          push_data.value_length = accum_next[srve_pkg::VLEN_W-1:0];
        end
        // ready for the next datagram
        step_next    = srve_pkg::STEP_MESSAGE;
        phase_next   = srve_pkg::PH_TAG;
        left_next    = '0;
        accum_next   = '0;
        tag_next     = '0;
        pos_next     = '0;
        skip_next    = '0;
        req_end_next = '0;
        err_next     = srve_pkg::ST_OK;
      end
    end
  end

endmodule

### sv/srve_fifo.sv
module srve_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  srve_pkg::out_t    push_data,
  input  logic              pop,
  output srve_pkg::q_stat_t q_stat,
  output srve_pkg::out_t    head
);

  srve_pkg::out_t                entries [srve_pkg::QDEPTH];
  logic [srve_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [srve_pkg::QCNT_W-1:0]   count;

  assign q_stat.full  = (count == srve_pkg::QCNT_W'(srve_pkg::QDEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

### sv/srve_back.sv
module srve_back (
  input  logic              clk,
  input  logic              rst,
  input  srve_pkg::q_stat_t q_stat,
  input  srve_pkg::out_t    head,
  input  logic              res_stall,
  output logic              pop,
  output logic              res_valid,
  output srve_pkg::out_t    res_data
);

  // refill whenever the output register is empty or being taken
  assign pop = !q_stat.empty && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_data <= head;
    end
  end

endmodule

### sv/snmp_response_value_extractor.sv
// snmp v1 response value extractor: takes a datagram one byte per transaction on the rx
// channel (last_byte marks its final byte) and walks the fixed ber path down to the
// first varbind value, checking the sequence and oid tags; value content bytes leave on
// the res channel as they arrive, and the final byte yields one transaction with done_res,
// status, value_tag and value_length. a byte that is neither value content nor the last
// byte yields no transaction. rate is one byte per cycle while the queue is not full: the
// front parser finishes each byte's header update (length add and compare against the
// largest declared end) as the byte is taken. a result is written into a four-entry queue
// by the edge that takes its byte, then moves from the queue head into the output register,
// which is refilled when empty or being taken; rx_stall rises only when the queue is full.
// when status is not ok the value bytes already passed out are to be discarded.
module snmp_response_value_extractor (
  input  logic           clk,
  input  logic           rst,
  input  logic           rx_valid,
  output logic           rx_stall,
  input  srve_pkg::in_t  rx_data,
  output logic           res_valid,
  input  logic           res_stall,
  output srve_pkg::out_t res_data
);

  // front to queue
  logic              push;
  srve_pkg::out_t    push_data;

  // queue to back
  logic              pop;
  srve_pkg::q_stat_t q_stat;
  srve_pkg::out_t    head;

  // byte parser, one header step per byte
  srve_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_data   (rx_data),
    .q_stat    (q_stat),
    .rx_stall  (rx_stall),
    .push      (push),
    .push_data (push_data)
  );

  // short queue decouples parser from the consumer
  srve_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_stat    (q_stat),
    .head      (head)
  );

  // output register toward the consumer
  srve_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head      (head),
    .res_stall (res_stall),
    .pop       (pop),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

endmodule

### sv/srve_checker.sv
`include "snmp_response_value_extractor_defines.svh"

module srve_checker (
  input logic           clk,
  input logic           rst,
  input logic           res_valid,
  input logic           res_stall,
  input srve_pkg::out_t res_data
);

  // a stalled result stays put
  `SRVE_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_data))

  // every result is a value byte or a datagram end
  `SRVE_ASSERT_NOW(a_res_reason, res_valid, res_data.byte_valid || res_data.done_res)

  // status, tag and length only on the end of a datagram
  `SRVE_ASSERT_NOW(a_mid_clean, res_valid && !res_data.done_res,
                   res_data.status == srve_pkg::ST_OK && res_data.value_tag == 8'd0 &&
                   res_data.value_length == '0)

  // tag and length reported only with an ok status
  `SRVE_ASSERT_NOW(a_err_clean, res_valid && res_data.status != srve_pkg::ST_OK,
                   res_data.value_tag == 8'd0 && res_data.value_length == '0)

endmodule

bind snmp_response_value_extractor srve_checker u_srve_checker (.*);

### dv/tb_snmp_response_value_extractor.sv
`timescale 1ns / 100ps

module tb_snmp_response_value_extractor;

  // long length form marker and the octet count field behind it
  localparam logic [7:0] LONG_FORM = 8'h80;
  localparam logic [7:0] LEN_COUNT = 8'h7F;
  // bytes sent over the whole run, directed datagrams included
  localparam int TOTAL_BYTES = 1950;
  // cycles without any transaction before the run is declared hung
  localparam int QUIET_LIMIT = 3000;
  // drain after the last due result, to catch any result nobody asked for
  localparam int TAIL_CYCLES = 20;

  typedef logic [7:0] octets_t[$];

  // ways a generated response can be damaged, applied at one header
  typedef enum int {
    FLT_NONE,
    FLT_TAG,
    FLT_INDEF,
    FLT_OCTETS,
    FLT_OVERLEN,
    FLT_HUGE
  } fault_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rx_valid = 1'b0;
  logic rx_stall;
  srve_pkg::in_t rx_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  srve_pkg::out_t res_data;

  snmp_response_value_extractor uut (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_data  (rx_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data (res_data)
  );

  always #10 clk = ~clk;

  // bytes waiting to be offered and results the block still owes
  srve_pkg::in_t datagram_bytes[$];
  srve_pkg::out_t results_due[$];

  // bookkeeping for the summary
  int n_fail = 0;
  int n_datagrams = 0;
  int n_bytes = 0;
  int n_results = 0;
  int n_value_bytes = 0;
  int status_count[4];

  // generator knobs: which header gets which fault, forced length form
  fault_t fault_kind = FLT_NONE;
  int fault_at = -1;
  int form_pick = -1;

  // ---------------------------------------------------------------------------
  // parser prediction: a mirror of the ber walk, updated per accepted byte
  // ---------------------------------------------------------------------------
  logic [3:0] path_step;
  srve_pkg::phase_t hdr_phase;
  logic [2:0] len_octets_left;
  logic [31:0] len_value;
  logic [7:0] elem_tag;
  logic [srve_pkg::POS_W-1:0] rx_pos;
  logic [11:0] body_left;
  logic [11:0] declared_end;
  srve_pkg::status_t latched_err;

  function automatic void clear_parse();
    path_step = srve_pkg::STEP_MESSAGE;
    hdr_phase = srve_pkg::PH_TAG;
    len_octets_left = '0;
    len_value = '0;
    elem_tag = '0;
    rx_pos = '0;
    body_left = '0;
    declared_end = '0;
    latched_err = srve_pkg::ST_OK;
  endfunction

  // a header's length is complete: track the furthest declared end and move on
  function automatic void header_length_done(input logic [31:0] len);
    logic [32:0] stop_at;
    logic [11:0] clamped;
    stop_at = {21'd0, rx_pos} + {1'b0, len};
    if (stop_at > srve_pkg::MAX_DATAGRAM)
      stop_at = 33'(srve_pkg::MAX_DATAGRAM + 1);
    if (stop_at[11:0] > declared_end)
      declared_end = stop_at[11:0];
    clamped = (len > srve_pkg::MAX_DATAGRAM) ? 12'(srve_pkg::MAX_DATAGRAM + 1) : len[11:0];
    len_value = len;
    hdr_phase = srve_pkg::PH_TAG;
    if (latched_err != srve_pkg::ST_OK) begin
      // a bad tag lets its length count, then the walk stops
      path_step = srve_pkg::STEP_FINISHED;
    end else begin
      case (path_step)
        // constructed elements on the path are entered, not skipped
        srve_pkg::STEP_MESSAGE, srve_pkg::STEP_PDU, srve_pkg::STEP_VB_LIST,
        srve_pkg::STEP_VARBIND: path_step = path_step + 4'd1;
        srve_pkg::STEP_VALUE_HDR: begin
          if (len == 0) begin
            path_step = srve_pkg::STEP_FINISHED;
          end else begin
            path_step = srve_pkg::STEP_VALUE_DATA;
            body_left = clamped;
            hdr_phase = srve_pkg::PH_BODY;
          end
        end
        default: begin
          if (len == 0) begin
            path_step = path_step + 4'd1;
          end else begin
            body_left = clamped;
            hdr_phase = srve_pkg::PH_BODY;
          end
        end
      endcase
    end
  endfunction

  // one accepted byte: advance the walk and queue the result it causes
  function automatic void parse_datagram_byte(input srve_pkg::in_t item);
    srve_pkg::out_t r;
    logic [7:0] b;
    logic parse_it;
    logic tag_bad;
    logic [7:0] n_oct;
    srve_pkg::status_t st;
    r = '0;
    b = item.in_byte;
    parse_it = 1'b0;
    if (rx_pos <= srve_pkg::POS_MAX) begin
      rx_pos = rx_pos + 1'b1;
      parse_it = (rx_pos <= srve_pkg::POS_MAX);
    end
    if (parse_it && path_step < srve_pkg::STEP_FINISHED) begin
      case (hdr_phase)
        srve_pkg::PH_TAG: begin
          tag_bad = 1'b0;
          if ((path_step == srve_pkg::STEP_MESSAGE || path_step == srve_pkg::STEP_VB_LIST ||
               path_step == srve_pkg::STEP_VARBIND) && b != srve_pkg::TAG_SEQUENCE)
            tag_bad = 1'b1;
          if (path_step == srve_pkg::STEP_OID && b != srve_pkg::TAG_OID)
            tag_bad = 1'b1;
          elem_tag = b;
          if (tag_bad && latched_err == srve_pkg::ST_OK)
            latched_err = srve_pkg::ST_TAG;
          hdr_phase = srve_pkg::PH_LEN_FIRST;
        end
        srve_pkg::PH_LEN_FIRST: begin
          if ((b & LONG_FORM) == 0) begin
            header_length_done({24'd0, b});
          end else begin
            n_oct = b & LEN_COUNT;
            if (n_oct == 0 || n_oct > srve_pkg::MAX_LEN_OCTETS) begin
              // indefinite form or too many octets freezes at once
              if (latched_err == srve_pkg::ST_OK)
                latched_err = srve_pkg::ST_FORM;
              path_step = srve_pkg::STEP_FINISHED;
              hdr_phase = srve_pkg::PH_TAG;
            end else begin
              len_octets_left = n_oct[2:0];
              len_value = '0;
              hdr_phase = srve_pkg::PH_LEN_LONG;
            end
          end
        end
        srve_pkg::PH_LEN_LONG: begin
          len_value = {len_value[23:0], b};
          len_octets_left = len_octets_left - 3'd1;
          if (len_octets_left == 0)
            header_length_done(len_value);
        end
        default: begin
          // content: skipped, or streamed out when it is the value
          if (path_step == srve_pkg::STEP_VALUE_DATA) begin
            r.byte_valid = 1'b1;
            r.value_byte = b;
          end
          if (body_left > 0)
            body_left = body_left - 12'd1;
          if (body_left == 0) begin
            path_step = (path_step == srve_pkg::STEP_VALUE_DATA) ? srve_pkg::STEP_FINISHED
                                                                 : path_step + 4'd1;
            hdr_phase = srve_pkg::PH_TAG;
          end
        end
      endcase
    end
    if (item.last_byte) begin
      // oversize and truncation outrank a latched error
      if (rx_pos > srve_pkg::POS_MAX)
        st = srve_pkg::ST_TRUNC;
      else if (rx_pos < declared_end)
        st = srve_pkg::ST_TRUNC;
      else if (path_step != srve_pkg::STEP_FINISHED)
        st = srve_pkg::ST_TRUNC;
      else
        st = latched_err;
      r.done_res = 1'b1;
      r.status = st;
      if (st == srve_pkg::ST_OK) begin
        r.value_tag = elem_tag;
        r.value_length = len_value[srve_pkg::VLEN_W-1:0];
      end
      clear_parse();
    end
    if (r.byte_valid || item.last_byte)
      results_due = {results_due, r};
  endfunction

  // ---------------------------------------------------------------------------
  // datagram generation
  // ---------------------------------------------------------------------------
  function automatic octets_t rand_octets(input int n);
    octets_t q;
    int i;
    for (i = 0; i < n; i++)
      q = {q, 8'($urandom_range(0, 255))};
    return q;
  endfunction

  // ber length field, short or long form with a random or forced octet count
  function automatic octets_t len_field(input logic [31:0] len);
    octets_t q;
    int need;
    int n;
    int i;
    need = (len > 32'hFFFFFF) ? 4 : (len > 32'hFFFF) ? 3 : (len > 32'hFF) ? 2 : 1;
    if (form_pick >= 0)
      n = form_pick;
    else if ($urandom_range(0, 2) != 0)
      n = 0;
    else
      n = $urandom_range(need, 4);
    if (n == 0 && len < 128) begin
      q = {q, len[7:0]};
    end else begin
      if (n < need)
        n = need;
      q = {q, LONG_FORM | 8'(n)};
      for (i = n - 1; i >= 0; i--)
        q = {q, 8'(len >> (8 * i))};
    end
    return q;
  endfunction

  // tag and length of the header at path position at, with the armed fault
  function automatic octets_t hdr(input int at, input logic [7:0] tag,
                                  input logic [31:0] len);
    octets_t q;
    logic [7:0] t;
    t = tag;
    if (at == fault_at) begin
      case (fault_kind)
        FLT_TAG: t = tag ^ 8'($urandom_range(1, 255));
        FLT_OVERLEN: len = len + $urandom_range(1, 40);
        FLT_HUGE: len = ($urandom_range(0, 1) != 0) ? 32'hFFFFFFFF :
                        32'($urandom_range(srve_pkg::MAX_DATAGRAM + 1, 100000));
        default: ;
      endcase
    end
    q = {t};
    if (at == fault_at && fault_kind == FLT_INDEF)
      q = {q, LONG_FORM};
    else if (at == fault_at && fault_kind == FLT_OCTETS)
      q = {q, LONG_FORM | 8'($urandom_range(5, 127))};
    else
      q = {q, len_field(len)};
    return q;
  endfunction

  function automatic octets_t int_elem(input int at);
    octets_t c;
    c = rand_octets($urandom_range(0, 4));
    return {hdr(at, 8'h02, c.size()), c};
  endfunction

  // a get-response built inside out: value, varbind, list, pdu, message
  function automatic octets_t make_response(input int vlen);
    octets_t val;
    octets_t oid;
    octets_t comm;
    octets_t vb;
    octets_t vbl;
    octets_t pdu;
    octets_t msg;
    logic [7:0] vtag;
    logic [7:0] pdu_tag;
    val = rand_octets(vlen);
    oid = {8'h2B, rand_octets($urandom_range(1, 10))};
    comm = rand_octets($urandom_range(0, 12));
    case ($urandom_range(0, 6))
      0: vtag = 8'h02;
      1: vtag = 8'h04;
      2: vtag = 8'h06;
      3: vtag = 8'h40;
      4: vtag = 8'h41;
      5: vtag = 8'h43;
      default: vtag = 8'($urandom_range(0, 255));
    endcase
    pdu_tag = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'hA2;
    vb = {hdr(9, srve_pkg::TAG_OID, oid.size()), oid, hdr(10, vtag, val.size()), val};
    vbl = {hdr(8, srve_pkg::TAG_SEQUENCE, vb.size()), vb};
    pdu = {int_elem(4), int_elem(5), int_elem(6),
           hdr(7, srve_pkg::TAG_SEQUENCE, vbl.size()), vbl};
    msg = {hdr(1, 8'h02, 1), 8'h00, hdr(2, 8'h04, comm.size()), comm,
           hdr(3, pdu_tag, pdu.size()), pdu};
    return {hdr(0, srve_pkg::TAG_SEQUENCE, msg.size()), msg};
  endfunction

  function automatic void arm(input fault_t kind, input int at, input int form);
    fault_kind = kind;
    fault_at = at;
    form_pick = form;
  endfunction

  // hand a datagram to the driver, last_byte on its final byte
  function automatic void queue_datagram(input octets_t d);
    srve_pkg::in_t item;
    int i;
    for (i = 0; i < d.size(); i++) begin
      item.in_byte = d[i];
      item.last_byte = (i == d.size() - 1);
      datagram_bytes = {datagram_bytes, item};
    end
    n_datagrams++;
    n_bytes += d.size();
  endfunction

  // idle length: mostly none or short, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    else if (r < 99)
      return $urandom_range(4, 12);
    else
      return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one byte per transaction, random gaps, held while stalled
  // ---------------------------------------------------------------------------
  int rx_gap = 0;
  bit rx_calm = 1'b0;

  always @(posedge clk) begin
    srve_pkg::in_t next_item;
    if (rst) begin
      rx_valid <= 1'b0;
      rx_data <= '0;
    end else begin
      if (rx_valid && !rx_stall)
        parse_datagram_byte(rx_data);
      // calm stretches run back to back with no gaps at all
      if ($urandom_range(0, 299) == 0)
        rx_calm = !rx_calm;
      if (!rx_valid || !rx_stall) begin
        if (rx_gap != 0) begin
          rx_gap--;
          rx_valid <= 1'b0;
        end else if (datagram_bytes.size() != 0) begin
          next_item = datagram_bytes.pop_front();
          rx_data <= next_item;
          rx_valid <= 1'b1;
          rx_gap = rx_calm ? 0 : idle_len();
        end else begin
          rx_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure, each result checked against the oldest due
  // ---------------------------------------------------------------------------
  int res_hold = 0;
  bit res_calm = 1'b0;

  task automatic check_result(input srve_pkg::out_t got);
    srve_pkg::out_t want;
    if (results_due.size() == 0) begin
      $error("result with nothing due: byte_valid %0d value_byte %0h done_res %0d",
             got.byte_valid, got.value_byte, got.done_res);
      n_fail++;
    end else begin
      want = results_due.pop_front();
      if (got.byte_valid !== want.byte_valid) begin
        $error("byte_valid: expected %0d, got %0d", want.byte_valid, got.byte_valid);
        n_fail++;
      end
      if (got.value_byte !== want.value_byte) begin
        $error("value_byte: expected %0h, got %0h", want.value_byte, got.value_byte);
        n_fail++;
      end
      if (got.done_res !== want.done_res) begin
        $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
        n_fail++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        n_fail++;
      end
      if (got.value_tag !== want.value_tag) begin
        $error("value_tag: expected %0h, got %0h", want.value_tag, got.value_tag);
        n_fail++;
      end
      if (got.value_length !== want.value_length) begin
        $error("value_length: expected %0d, got %0d", want.value_length, got.value_length);
        n_fail++;
      end
    end
    n_results++;
    if (got.byte_valid === 1'b1)
      n_value_bytes++;
    if (got.done_res === 1'b1 && !$isunknown(got.status))
      status_count[got.status]++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall)
        check_result(res_data);
      if ($urandom_range(0, 299) == 0)
        res_calm = !res_calm;
      if (res_hold != 0)
        res_hold--;
      else if (!res_calm)
        res_hold = idle_len();
      res_stall <= (res_hold != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: no transaction on either side for too long means a hang
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((rx_valid && !rx_stall) || (res_valid && !res_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    octets_t d;
    int vlen;
    int roll;
    clear_parse();

    // single byte datagram: ends after its first tag byte
    d = {8'hFF};
    queue_datagram(d);
    // clean responses: short forms, four-octet long forms with an empty value, two-octet long forms
    arm(FLT_NONE, -1, 0);
    queue_datagram(make_response(4));
    arm(FLT_NONE, -1, 4);
    queue_datagram(make_response(0));
    arm(FLT_NONE, -1, 2);
    queue_datagram(make_response(2));
    // wrong tag at each checked header
    arm(FLT_TAG, 0, -1);
    queue_datagram(make_response(3));
    arm(FLT_TAG, 7, -1);
    queue_datagram(make_response(3));
    arm(FLT_TAG, 8, -1);
    queue_datagram(make_response(3));
    arm(FLT_TAG, 9, -1);
    queue_datagram(make_response(3));
    // indefinite length on the pdu, too many length octets on the value
    arm(FLT_INDEF, 3, -1);
    queue_datagram(make_response(3));
    arm(FLT_OCTETS, 10, -1);
    queue_datagram(make_response(3));
    // message claims far more than any datagram can hold
    arm(FLT_HUGE, 0, -1);
    queue_datagram(make_response(3));
    // value declared longer than what follows
    arm(FLT_OVERLEN, 10, -1);
    queue_datagram(make_response(5));
    // datagram cut in the middle of the value
    arm(FLT_NONE, -1, -1);
    d = make_response(20);
    d = d[0:d.size() - 6];
    queue_datagram(d);
    // long value streamed in one piece
    queue_datagram(make_response(200));

    // random traffic: mostly well-formed responses, the rest damaged or noise
    while (n_bytes < TOTAL_BYTES) begin
      arm(FLT_NONE, -1, -1);
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        case ($urandom_range(0, 3))
          0: arm(FLT_TAG, 0, -1);
          1: arm(FLT_TAG, 7, -1);
          2: arm(FLT_TAG, 8, -1);
          default: arm(FLT_TAG, 9, -1);
        endcase
      end else if (roll < 16) begin
        arm(FLT_INDEF, $urandom_range(0, 10), -1);
      end else if (roll < 22) begin
        arm(FLT_OCTETS, $urandom_range(0, 10), -1);
      end else if (roll < 32) begin
        arm(FLT_OVERLEN, $urandom_range(0, 10), -1);
      end else if (roll < 38) begin
        arm(FLT_HUGE, $urandom_range(0, 10), -1);
      end
      vlen = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 150) : $urandom_range(0, 12);
      d = make_response(vlen);
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        d = d[0:$urandom_range(0, d.size() - 2)];
      end else if (roll < 20) begin
        d = {d, rand_octets($urandom_range(1, 20))};
      end else if (roll < 28) begin
        // noise, sometimes opening like a message
        d = rand_octets($urandom_range(1, 40));
        if ($urandom_range(0, 1) != 0)
          d[0] = srve_pkg::TAG_SEQUENCE;
      end
      queue_datagram(d);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (datagram_bytes.size() != 0 || rx_valid || results_due.size() != 0)
      @(negedge clk);
    // anything arriving now is a result nobody asked for
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("sent %0d datagrams (%0d bytes): clean, damaged headers, cuts, noise",
             n_datagrams, n_bytes);
    $display("checked %0d results, %0d value bytes; status ok/trunc/tag/form %0d/%0d/%0d/%0d",
             n_results, n_value_bytes, status_count[0], status_count[1],
             status_count[2], status_count[3]);
    if (n_fail == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
